### design/assert_macros.svh
// Assertion macros shared by the interrupt level controller RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ILC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ILC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### design/ilc_pkg.sv
// Shared types and constants of the interrupt level controller.
// Depends on nothing; imported by every module of the block.
`default_nettype none

package ilc_pkg;

    localparam int SLOTS_PER_CPU = 32;
    localparam int SLOT_W        = $clog2(SLOTS_PER_CPU);
    localparam int NUM_CPUS      = 3;
    localparam int NUM_LEVELS    = 8;
    localparam int LVL_IDX_W     = $clog2(NUM_LEVELS);

    typedef enum logic [1:0] {
        REQ_READ   = 2'd0,
        REQ_WRITE  = 2'd1,
        REQ_VBLANK = 2'd2,
        REQ_POS    = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        ACT_NONE    = 3'd0,
        ACT_ASSERT  = 3'd1,
        ACT_CLEAR   = 3'd2,
        ACT_HOLD    = 3'd3,
        ACT_RST_ON  = 3'd4,
        ACT_RST_OFF = 3'd5,
        ACT_KICK    = 3'd6
    } action_t;

    localparam logic [1:0] CPU_PRIMARY   = 2'd0;
    localparam logic [1:0] CPU_SECONDARY = 2'd1;
    localparam logic [1:0] CPU_GRAPHICS  = 2'd2;
    localparam logic [1:0] CPU_UNKNOWN   = 2'd3;

    localparam logic [2:0] TGT_NONE  = 3'd0;
    localparam logic [2:0] TGT_SOUND = 3'd3;
    localparam logic [2:0] TGT_SUBS  = 3'd4;

    localparam logic [LVL_IDX_W-1:0] LVL_CPUIRQ = 3'd3;
    localparam logic [LVL_IDX_W-1:0] LVL_POS    = 3'd5;
    localparam logic [LVL_IDX_W-1:0] LVL_VBLANK = 3'd7;

    localparam logic [SLOT_W-1:0] SLOT_ACK_CROSS0 = 5'd8;
    localparam logic [SLOT_W-1:0] SLOT_ACK_CROSS1 = 5'd10;
    localparam logic [SLOT_W-1:0] SLOT_STATUS     = 5'd16;
    localparam logic [SLOT_W-1:0] SLOT_SOUND_RST  = 5'd17;
    localparam logic [SLOT_W-1:0] SLOT_SUBS_RST   = 5'd18;

    localparam logic [15:0] STATUS_DATA = 16'hFFFF;

    typedef struct packed {
        action_t     action;
        logic [2:0]  target;
        logic [2:0]  irq_level;
        logic [15:0] read_data;
        logic        last;
    } result_t;

    typedef struct packed {
        logic                 en;
        logic [1:0]           cpu;
        logic [LVL_IDX_W-1:0] idx;
        logic [2:0]           data;
    } level_wr_t;

endpackage

`default_nettype wire

### design/ilc_level_store.sv
// Interrupt level registers: eight 3-bit levels for each of the three CPUs.
// Depends on ilc_pkg; instantiated by interrupt_level_controller_unit.
`default_nettype none

module ilc_level_store (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ilc_pkg::level_wr_t            wr,
    input  logic [1:0]                    rd_cpu,
    input  logic [ilc_pkg::LVL_IDX_W-1:0] rd_idx,
    input  logic                          alt_is_slave,
    output logic [2:0]                    rd_level,
    output logic [2:0]                    alt_cpuirq_level
);
    import ilc_pkg::*;

    logic [2:0] lvl_reg [NUM_CPUS][NUM_LEVELS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NUM_CPUS; c++)
            begin
                for (int l = 0; l < NUM_LEVELS; l++)
                begin
                    lvl_reg[c][l] <= '0;
                end
            end
        end
        else if (wr.en && (wr.cpu != CPU_UNKNOWN))
        begin
            lvl_reg[wr.cpu][wr.idx] <= wr.data;
        end
    end

    always_comb
    begin
        rd_level = '0;
        if (rd_cpu != CPU_UNKNOWN)
        begin
            rd_level = lvl_reg[rd_cpu][rd_idx];
        end
    end

    assign alt_cpuirq_level = alt_is_slave ? lvl_reg[CPU_SECONDARY][LVL_CPUIRQ]
                                           : lvl_reg[CPU_PRIMARY][LVL_CPUIRQ];

endmodule

`default_nettype wire

### design/ilc_decode.sv
// Request decoder: turns one registered request into one or two result items
// and the level register update. Depends on ilc_pkg.
`default_nettype none

module ilc_decode (
    input  ilc_pkg::req_t                 req,
    input  logic [1:0]                    cpu,
    input  logic [16:0]                   offset,
    input  logic [15:0]                   write_data,
    input  logic                          system21_mode,
    input  logic [2:0]                    own_level,
    input  logic [2:0]                    alt_level,
    output logic [ilc_pkg::LVL_IDX_W-1:0] rd_idx,
    output logic                          alt_is_slave,
    output ilc_pkg::level_wr_t            level_wr,
    output ilc_pkg::result_t              item0,
    output ilc_pkg::result_t              item1,
    output logic                          two_items
);
    import ilc_pkg::*;

    logic [SLOT_W-1:0] slot;
    logic              is_wr;
    logic [15:0]       data_eff;
    logic [15:0]       rd_data;
    logic              is_ack;

    assign slot         = offset[16:12];
    assign is_wr        = (req == REQ_WRITE);
    assign data_eff     = is_wr ? write_data : 16'd0;
    assign rd_data      = ((req == REQ_READ) && (slot == SLOT_STATUS)) ? STATUS_DATA : 16'd0;
    assign is_ack       = (slot[4:3] == 2'b01);
    assign alt_is_slave = (cpu == CPU_PRIMARY);

    always_comb
    begin
        level_wr.en   = is_wr && (cpu != CPU_UNKNOWN) && (slot[4:3] == 2'b00);
        level_wr.cpu  = cpu;
        level_wr.idx  = slot[LVL_IDX_W-1:0];
        level_wr.data = write_data[2:0];
    end

    always_comb
    begin
        unique case (req)
            REQ_VBLANK: rd_idx = LVL_VBLANK;
            REQ_POS:    rd_idx = LVL_POS;
            default:    rd_idx = slot[LVL_IDX_W-1:0];
        endcase
    end

    always_comb
    begin
        item0     = '{action: ACT_NONE, target: TGT_NONE, irq_level: 3'd0,
                      read_data: 16'd0, last: 1'b1};
        item1     = '{action: ACT_NONE, target: TGT_NONE, irq_level: 3'd0,
                      read_data: 16'd0, last: 1'b1};
        two_items = 1'b0;

        if (cpu != CPU_UNKNOWN)
        begin
            unique case (req)
                REQ_VBLANK:
                begin
                    item0.action    = ACT_HOLD;
                    item0.target    = {1'b0, cpu};
                    item0.irq_level = own_level;
                end
                REQ_POS:
                begin
                    if ((own_level != 3'd0) && ((cpu == CPU_GRAPHICS) || !system21_mode))
                    begin
                        item0.action    = ACT_ASSERT;
                        item0.target    = {1'b0, cpu};
                        item0.irq_level = own_level;
                    end
                end
                default:
                begin
                    item0.read_data = rd_data;
                    item1.read_data = rd_data;
                    if (is_ack)
                    begin
                        if (is_wr && ((slot == SLOT_ACK_CROSS0) || (slot == SLOT_ACK_CROSS1)))
                        begin
                            item0.action    = ACT_ASSERT;
                            item0.target    = {2'b00, alt_is_slave};
                            item0.irq_level = alt_level;
                            item0.last      = 1'b0;
                            item1.action    = ACT_CLEAR;
                            item1.target    = {1'b0, cpu};
                            item1.irq_level = own_level;
                            two_items       = 1'b1;
                        end
                        else
                        begin
                            item0.action    = ACT_CLEAR;
                            item0.target    = {1'b0, cpu};
                            item0.irq_level = own_level;
                        end
                    end
                    else if (((slot == SLOT_SOUND_RST) || (slot == SLOT_SUBS_RST))
                             && (cpu == CPU_PRIMARY))
                    begin
                        item0.action = data_eff[0] ? ACT_RST_OFF : ACT_RST_ON;
                        item0.target = (slot == SLOT_SOUND_RST) ? TGT_SOUND : TGT_SUBS;
                        if ((slot == SLOT_SOUND_RST) && system21_mode && data_eff[2])
                        begin
                            item0.last   = 1'b0;
                            item1.action = ACT_KICK;
                            two_items    = 1'b1;
                        end
                    end
                end
            endcase
        end
    end

endmodule

`default_nettype wire

### design/interrupt_level_controller_unit.sv
// Top level of the interrupt level controller: input register, decoder,
// level registers and a two-entry result buffer. Depends on ilc_pkg,
// ilc_decode, ilc_level_store and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

// A request is held in an input register, decoded in one pass and its result
// items are placed in a two-entry output buffer, which drains one result per
// cycle while m_axis_tready is high. Requests that give one result run at one
// per cycle when the output does not stall; a request that gives two results
// (a cross interrupt on acknowledge slot 8 or 10, or a sound reset write with
// the DSP kick) keeps the next request waiting until its second result is taken.
// A request passes the input register and then the output buffer register.
// The level registers are cleared by reset at once; the block is ready right after reset.
module interrupt_level_controller_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // cpu_id[1:0], offset[18:2], write_data[34:19]
    input  logic [1:0]  s_axis_tuser,   // req_type[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // target[2:0], irq_level[5:3], read_data[21:6]
    output logic [2:0]  m_axis_tuser,   // action[2:0]
    output logic        m_axis_tlast
);
    import ilc_pkg::*;

    logic        system21_mode_reg;
    logic        in_valid_reg, in_valid_next;
    req_t        in_req_reg;
    logic [1:0]  in_cpu_reg;
    logic [16:0] in_offset_reg;
    logic [15:0] in_data_reg;
    logic [1:0]  out_cnt_reg, out_cnt_next;
    result_t     out_item0_reg, out_item0_next;
    result_t     out_item1_reg, out_item1_next;

    logic                 in_fire;
    logic                 out_fire;
    logic                 buf_free;
    logic                 load;
    logic [LVL_IDX_W-1:0] rd_idx;
    logic                 alt_is_slave;
    logic [2:0]           own_level;
    logic [2:0]           alt_level;
    level_wr_t            dec_wr;
    level_wr_t            store_wr;
    result_t              dec_item0;
    result_t              dec_item1;
    logic                 dec_two;

    ilc_decode u_decode (
        .req           (in_req_reg),
        .cpu           (in_cpu_reg),
        .offset        (in_offset_reg),
        .write_data    (in_data_reg),
        .system21_mode (system21_mode_reg),
        .own_level     (own_level),
        .alt_level     (alt_level),
        .rd_idx        (rd_idx),
        .alt_is_slave  (alt_is_slave),
        .level_wr      (dec_wr),
        .item0         (dec_item0),
        .item1         (dec_item1),
        .two_items     (dec_two)
    );

    always_comb
    begin
        store_wr    = dec_wr;
        store_wr.en = dec_wr.en && load;
    end

    ilc_level_store u_level_store (
        .clk              (clk),
        .rst_n            (rst_n),
        .wr               (store_wr),
        .rd_cpu           (in_cpu_reg),
        .rd_idx           (rd_idx),
        .alt_is_slave     (alt_is_slave),
        .rd_level         (own_level),
        .alt_cpuirq_level (alt_level)
    );

    assign m_axis_tvalid = (out_cnt_reg != 2'd0);
    assign out_fire      = m_axis_tvalid && m_axis_tready;
    assign buf_free      = (out_cnt_reg == 2'd0) || ((out_cnt_reg == 2'd1) && out_fire);
    assign load          = in_valid_reg && buf_free;
    assign s_axis_tready = !in_valid_reg || buf_free;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    assign m_axis_tuser = out_item0_reg.action;
    assign m_axis_tdata = {2'b00, out_item0_reg.read_data, out_item0_reg.irq_level,
                           out_item0_reg.target};
    assign m_axis_tlast = out_item0_reg.last;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_fire)
        begin
            in_valid_next = 1'b1;
        end
        else if (load)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_cnt_next   = out_cnt_reg;
        out_item0_next = out_item0_reg;
        out_item1_next = out_item1_reg;
        if (out_fire)
        begin
            out_item0_next = out_item1_reg;
            out_cnt_next   = out_cnt_reg - 2'd1;
        end
        if (load)
        begin
            out_item0_next = dec_item0;
            out_item1_next = dec_item1;
            out_cnt_next   = dec_two ? 2'd2 : 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            system21_mode_reg <= 1'b0;
            in_valid_reg      <= 1'b0;
            out_cnt_reg       <= 2'd0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                system21_mode_reg <= cfg_wr_data;
            end
            in_valid_reg <= in_valid_next;
            out_cnt_reg  <= out_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_req_reg    <= req_t'(s_axis_tuser);
            in_cpu_reg    <= s_axis_tdata[1:0];
            in_offset_reg <= s_axis_tdata[18:2];
            in_data_reg   <= s_axis_tdata[34:19];
        end
        out_item0_reg <= out_item0_next;
        out_item1_reg <= out_item1_next;
    end

    `ILC_ASSERT_IMP(a_cnt_range, clk, rst_n, 1'b1, out_cnt_reg != 2'd3)
    `ILC_ASSERT_IMP(a_pair_not_last, clk, rst_n, out_cnt_reg == 2'd2, !out_item0_reg.last)
    `ILC_ASSERT_IMP(a_kick_mode, clk, rst_n,
                    m_axis_tvalid && (out_item0_reg.action == ACT_KICK), system21_mode_reg)
    `ILC_ASSERT_NXT(a_load_shows, clk, rst_n, load, m_axis_tvalid)

endmodule

`default_nettype wire

### tb/sv/ilc_scoreboard.sv
`timescale 1ns / 1ps
// Scoreboard for the interrupt level controller: watches the configuration port and both
// stream channels, predicts the result transfers and compares them as they arrive.
// Depends on ilc_pkg for the request, action and result types.
module ilc_scoreboard (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // cpu_id[1:0], offset[18:2], write_data[34:19]
    input  logic [1:0]  s_axis_tuser,   // req_type[1:0]
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [23:0] m_axis_tdata,   // target[2:0], irq_level[5:3], read_data[21:6]
    input  logic [2:0]  m_axis_tuser,   // action[2:0]
    input  logic        m_axis_tlast,
    output int unsigned mismatch_count,
    output int unsigned outstanding
);
    import ilc_pkg::*;

    logic [2:0] level_slots [NUM_CPUS][SLOTS_PER_CPU];
    logic       sys21_mode;
    result_t    pending_results [$];

    function automatic result_t make_result(action_t act, logic [2:0] tgt, logic [2:0] lvl,
                                            logic [15:0] rdata);
        result_t item;
        item.action    = act;
        item.target    = tgt;
        item.irq_level = lvl;
        item.read_data = rdata;
        item.last      = 1'b0;
        return item;
    endfunction

    function automatic void predict_results(req_t req, logic [1:0] cpu, logic [16:0] off,
                                            logic [15:0] wdata);
        result_t     items [$];
        logic [4:0]  slot;
        logic [1:0]  peer;
        logic [2:0]  lvl;
        logic [15:0] data;
        logic [15:0] rdata;
        logic        wr;
        slot  = off[16:12];
        peer  = (cpu == CPU_PRIMARY) ? CPU_SECONDARY : CPU_PRIMARY;
        wr    = (req == REQ_WRITE);
        data  = wr ? wdata : 16'd0;
        rdata = (!wr && slot == SLOT_STATUS) ? STATUS_DATA : 16'd0;
        if (cpu > CPU_GRAPHICS) begin
            items.push_back(make_result(ACT_NONE, TGT_NONE, 3'd0, 16'd0));
        end
        else if (req == REQ_VBLANK) begin
            items.push_back(make_result(ACT_HOLD, {1'b0, cpu},
                                        level_slots[cpu][{2'b00, LVL_VBLANK}], 16'd0));
        end
        else if (req == REQ_POS) begin
            lvl = level_slots[cpu][{2'b00, LVL_POS}];
            if (lvl != 3'd0 && (cpu == CPU_GRAPHICS || !sys21_mode))
                items.push_back(make_result(ACT_ASSERT, {1'b0, cpu}, lvl, 16'd0));
            else
                items.push_back(make_result(ACT_NONE, TGT_NONE, 3'd0, 16'd0));
        end
        else begin
            // The write lands in its slot before any level is looked up.
            if (wr)
                level_slots[cpu][slot] = data[2:0];
            if (slot >= SLOT_ACK_CROSS0 && slot < SLOT_STATUS) begin
                if (wr && (slot == SLOT_ACK_CROSS0 || slot == SLOT_ACK_CROSS1))
                    items.push_back(make_result(ACT_ASSERT, {1'b0, peer},
                                                level_slots[peer][{2'b00, LVL_CPUIRQ}],
                                                rdata));
                items.push_back(make_result(ACT_CLEAR, {1'b0, cpu},
                                            level_slots[cpu][{2'b00, slot[2:0]}], rdata));
            end
            else if ((slot == SLOT_SOUND_RST || slot == SLOT_SUBS_RST) &&
                     cpu == CPU_PRIMARY) begin
                items.push_back(make_result(data[0] ? ACT_RST_OFF : ACT_RST_ON,
                                            (slot == SLOT_SOUND_RST) ? TGT_SOUND : TGT_SUBS,
                                            3'd0, rdata));
                if (slot == SLOT_SOUND_RST && sys21_mode && data[2])
                    items.push_back(make_result(ACT_KICK, TGT_NONE, 3'd0, rdata));
            end
            else begin
                items.push_back(make_result(ACT_NONE, TGT_NONE, 3'd0, rdata));
            end
        end
        items[items.size() - 1].last = 1'b1;
        foreach (items[i])
            pending_results.push_back(items[i]);
    endfunction

    always @(posedge clk or negedge rst_n) begin
        result_t got;
        result_t want;
        if (!rst_n) begin
            foreach (level_slots[c, s])
                level_slots[c][s] = 3'd0;
            sys21_mode = 1'b0;
            pending_results.delete();
            mismatch_count = 0;
            outstanding    = 0;
        end
        else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.action    = action_t'(m_axis_tuser);
                got.target    = m_axis_tdata[2:0];
                got.irq_level = m_axis_tdata[5:3];
                got.read_data = m_axis_tdata[21:6];
                got.last      = m_axis_tlast;
                if (pending_results.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected result transfer: expected none, got",
                             $time,
                             " action=%0d target=%0d lvl=%0d data=%h last=%0d",
                             got.action, got.target, got.irq_level, got.read_data,
                             got.last);
                end
                else begin
                    want = pending_results.pop_front();
                    if (got.action !== want.action || got.target !== want.target ||
                        got.irq_level !== want.irq_level || got.read_data !== want.read_data ||
                        got.last !== want.last) begin
                        mismatch_count++;
                        $display("%0t: mismatch: expected", $time,
                                 " action=%0d target=%0d lvl=%0d data=%h last=%0d,",
                                 want.action, want.target, want.irq_level,
                                 want.read_data, want.last,
                                 " got action=%0d target=%0d lvl=%0d data=%h last=%0d",
                                 got.action, got.target, got.irq_level, got.read_data,
                                 got.last);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                predict_results(req_t'(s_axis_tuser), s_axis_tdata[1:0], s_axis_tdata[18:2],
                                s_axis_tdata[34:19]);
            if (cfg_wr_en)
                sys21_mode = cfg_wr_data;
            outstanding = pending_results.size();
        end
    end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Top of the interrupt level controller testbench: clock, reset, request stimulus, result
// back-pressure and the verdict. Depends on ilc_pkg, ilc_scoreboard and the controller RTL.
module tb_top;
    import ilc_pkg::*;

    localparam int unsigned HOLD_CYCLES  = 80;
    localparam int unsigned PHASE_ITEMS  = 236;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_wr_en;
    logic        cfg_wr_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;

    int unsigned mismatch_count;
    int unsigned outstanding;
    int unsigned idle_pct  = 0;
    int unsigned stall_pct = 0;
    int unsigned hold_left = 0;
    logic        hold_trigger = 1'b0;
    logic        hold_seen    = 1'b0;

    interrupt_level_controller_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    ilc_scoreboard u_scoreboard (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser),
        .m_axis_tlast   (m_axis_tlast),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // A toggle of hold_trigger starts one long stretch with the result side held off.
    always @(posedge clk)
    begin
        if (hold_trigger != hold_seen)
        begin
            hold_seen = hold_trigger;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic logic [16:0] slot_offset(logic [4:0] slot, logic [11:0] low);
        return {slot, low};
    endfunction

    task automatic send_request(req_t req, logic [1:0] cpu, logic [16:0] off,
                                logic [15:0] wdata);
        while ($urandom_range(99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'd0, wdata, off, cpu};
        s_axis_tuser  <= req;
        do @(posedge clk); while (!s_axis_tready);
    endtask

    task automatic send_random();
        req_t        req;
        logic [1:0]  cpu;
        logic [4:0]  slot;
        int unsigned pick;
        pick = $urandom_range(99);
        cpu  = ($urandom_range(19) == 0) ? CPU_UNKNOWN : 2'($urandom_range(2));
        slot = ($urandom_range(3) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(18));
        if (pick < 12)
            req = REQ_VBLANK;
        else if (pick < 24)
            req = REQ_POS;
        else if (pick < 62)
            req = REQ_WRITE;
        else
            req = REQ_READ;
        if (pick >= 95)
            send_request(req_t'($urandom_range(3)), 2'($urandom_range(3)), 17'($urandom),
                         16'($urandom));
        else
            send_request(req, cpu, slot_offset(slot, 12'($urandom)), 16'($urandom));
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(negedge clk); while (outstanding != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_mode(logic mode);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mode;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial
    begin
        int unsigned phase;
        int unsigned i;
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        set_mode(1'b0);

        send_request(REQ_WRITE, CPU_PRIMARY, slot_offset({2'b00, LVL_VBLANK}, 12'h000),
                     16'h0006);
        send_request(REQ_VBLANK, CPU_PRIMARY, 17'h00000, 16'h0000);
        send_request(REQ_WRITE, CPU_PRIMARY, slot_offset({2'b00, LVL_POS}, 12'hFFF),
                     16'hFFFB);
        send_request(REQ_POS, CPU_PRIMARY, 17'h00000, 16'h0000);
        send_request(REQ_POS, CPU_SECONDARY, 17'h00000, 16'h0000);
        send_request(REQ_WRITE, CPU_SECONDARY, slot_offset({2'b00, LVL_CPUIRQ}, 12'h000),
                     16'hFFFF);
        send_request(REQ_WRITE, CPU_PRIMARY, slot_offset(SLOT_ACK_CROSS0, 12'h000), 16'h0000);
        send_request(REQ_WRITE, CPU_SECONDARY, slot_offset(SLOT_ACK_CROSS1, 12'hABC),
                     16'h0001);
        send_request(REQ_WRITE, CPU_GRAPHICS, slot_offset(SLOT_ACK_CROSS0, 12'h000), 16'h0002);
        send_request(REQ_READ, CPU_PRIMARY, slot_offset(SLOT_ACK_CROSS0, 12'h000), 16'hFFFF);
        send_request(REQ_READ, CPU_SECONDARY, slot_offset(5'd15, 12'hFFF), 16'h0000);
        send_request(REQ_READ, CPU_PRIMARY, slot_offset(SLOT_STATUS, 12'h000), 16'h0000);
        send_request(REQ_READ, CPU_GRAPHICS, slot_offset(SLOT_STATUS, 12'hFFF), 16'h5555);
        send_request(REQ_WRITE, CPU_PRIMARY, slot_offset(SLOT_STATUS, 12'h000), 16'h1234);
        send_request(REQ_WRITE, CPU_PRIMARY, slot_offset(SLOT_SOUND_RST, 12'h000), 16'h0001);
        send_request(REQ_READ, CPU_PRIMARY, slot_offset(SLOT_SOUND_RST, 12'h000), 16'hFFFF);
        send_request(REQ_WRITE, CPU_PRIMARY, slot_offset(SLOT_SUBS_RST, 12'h000), 16'hFFFE);
        send_request(REQ_WRITE, CPU_SECONDARY, slot_offset(SLOT_SOUND_RST, 12'h000),
                     16'h0005);
        send_request(REQ_WRITE, CPU_GRAPHICS, slot_offset({2'b00, LVL_POS}, 12'h000),
                     16'h0002);
        send_request(REQ_POS, CPU_GRAPHICS, 17'h00000, 16'h0000);
        send_request(REQ_WRITE, CPU_UNKNOWN, 17'h1FFFF, 16'hFFFF);
        send_request(REQ_READ, CPU_PRIMARY, 17'h1FFFF, 16'h0000);
        drain_results();
        set_mode(1'b1);
        send_request(REQ_WRITE, CPU_PRIMARY, slot_offset(SLOT_SOUND_RST, 12'h000), 16'h0005);
        send_request(REQ_POS, CPU_PRIMARY, 17'h00000, 16'h0000);
        send_request(REQ_POS, CPU_GRAPHICS, 17'h00000, 16'h0000);
        send_request(REQ_WRITE, CPU_PRIMARY, slot_offset(SLOT_SOUND_RST, 12'h000), 16'h0004);
        send_request(REQ_VBLANK, CPU_UNKNOWN, 17'h00000, 16'h0000);

        for (phase = 0; phase < 4; phase++)
        begin
            drain_results();
            set_mode(phase[0]);
            idle_pct  = (phase == 1) ? 52 : (phase == 3) ? 14 : 0;
            stall_pct = (phase == 2) ? 52 : (phase == 3) ? 14 : 0;
            for (i = 0; i < PHASE_ITEMS; i++)
            begin
                if (phase == 0 && i == 30)
                    hold_trigger = ~hold_trigger;
                if (phase == 0 && i == 150)
                    drain_results();
                send_random();
            end
        end

        drain_results();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && outstanding == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

### sim.f
+incdir+design
design/ilc_pkg.sv
design/ilc_level_store.sv
design/ilc_decode.sv
design/interrupt_level_controller_unit.sv
tb/sv/ilc_scoreboard.sv
tb/sv/tb_top.sv
